// ===== sv/rmf_pkg.sv =====
// ----------------------------------------------------------------------------
// rmf_pkg: shared types and constants of the rgb 3x3 median filter
// Pixel layout, channel widths, register codes and the control struct that
// travels from the window stage to the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

package rmf_pkg;

   // channel and pixel widths, red in the lowest byte
   localparam int CHAN_W     = 8;
   localparam int NUM_LANES  = 3;
   localparam int PIX_W      = CHAN_W * NUM_LANES;
   localparam int WIN_SIZE   = 9;

   // frame geometry
   localparam int ROW_W      = 12;
   localparam int HEIGHT_W   = 13;
   localparam int MIN_DIM    = 3;
   localparam int MAX_HEIGHT = 4096;

   // configuration port
   localparam int CFG_WIDTH_W        = 11;
   localparam int CFG_HEIGHT_W       = 13;
   localparam int CSR_INDEX_W        = 1;
   localparam int CSR_DATA_W         = 13;
   localparam int RESET_IMAGE_WIDTH  = 1024;
   localparam int RESET_IMAGE_HEIGHT = 768;

   // register stages inside one median lane
   localparam int LANE_LAT = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_IMAGE_WIDTH  = 1'b0,
      REG_IMAGE_HEIGHT = 1'b1
   } csr_reg_type;

   typedef logic [CHAN_W-1:0] chan_type;
   typedef logic [PIX_W-1:0]  pixel_type;

   // one channel of the 3x3 window, row-major, newest column at the right
   typedef logic [WIN_SIZE-1:0][CHAN_W-1:0] window_chan_type;

   // what the output stage needs to know about one result
   typedef struct packed {
      logic      valid;
      logic      interior;
      logic      last;
      pixel_type raw;
   } emit_ctrl_type;

endpackage

`default_nettype wire

// ===== sv/rgb_median_3x3_filter.sv =====
// ----------------------------------------------------------------------------
// rgb_median_3x3_filter: per-channel 3x3 median filter for rgb pixels
// Raster-order pixel stream in, filtered pixel stream out; border rows and
// columns pass through unchanged.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one pixel a beat (tuser low) or a flush beat (tuser high).
//   rsp_* carries the filtered pixel; tlast marks the last pixel of a frame.
//   csr_* writes image_width (index 0) or image_height (index 1); a write
//   restarts the frame counters. Write only while the block is idle.
//   Each result trails its input by image_width+1 pixels. After the last
//   pixel of a frame, image_width+1 flush beats drain the tail; pixels of
//   the next frame push the tail out as well.
//   Throughput is one beat per clock while the skid stage is empty: the line
//   store ram does one read and one write a cycle and the three median lanes
//   are fully pipelined. From the accepted beat that produces a result to
//   rsp_tvalid, it passes the ram read, window, three lane stages and output
//   register. Reset is synchronous; the line stores are not cleared, their
//   contents are unused until written.
//   When rsp_tready is low, one more result is caught in a skid stage and
//   req_tready then drops until the stage is emptied.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_median_3x3_filter #(
   parameter int MAX_WIDTH = 1024
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // request channel
   input  wire logic                               req_tvalid,
   output      logic                               req_tready,
   input  wire logic [rmf_pkg::PIX_W-1:0]          req_tdata,   // red_in, green_in, blue_in
   input  wire logic                               req_tuser,   // flush
   // response channel
   output      logic                               rsp_tvalid,
   input  wire logic                               rsp_tready,
   output      logic [rmf_pkg::PIX_W-1:0]          rsp_tdata,   // red_out, green_out, blue_out
   output      logic                               rsp_tlast,   // frame_last
   // configuration channel
   input  wire logic                               csr_valid,
   output      logic                               csr_ready,
   input  wire logic [rmf_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [rmf_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int WID_W       = $clog2(MAX_WIDTH + 1);
   localparam int PEND_W      = $clog2(MAX_WIDTH + 2);
   localparam int LINE_W      = 2 * rmf_pkg::PIX_W;
   localparam int RESET_WIDTH = (rmf_pkg::RESET_IMAGE_WIDTH > MAX_WIDTH) ?
                                MAX_WIDTH : rmf_pkg::RESET_IMAGE_WIDTH;

   // configuration
   logic [WID_W-1:0]             eff_width_in, eff_width_ff;
   logic [rmf_pkg::HEIGHT_W-1:0] eff_height_in, eff_height_ff;
   logic [31:0]                  width_raw, height_raw;
   logic [WID_W-1:0]             width_clamped;
   logic [rmf_pkg::HEIGHT_W-1:0] height_clamped;
   logic                         restart;

   // frame position and pending count
   logic [COL_W-1:0]             in_col_in, in_col_ff;
   logic [rmf_pkg::ROW_W-1:0]    in_row_in, in_row_ff;
   logic [COL_W-1:0]             out_col_in, out_col_ff;
   logic [rmf_pkg::ROW_W-1:0]    out_row_in, out_row_ff;
   logic [PEND_W-1:0]            pending_in, pending_ff;

   // accept stage decode
   logic                         advance;
   logic                         ctrl_ready;
   logic                         accept;
   logic                         is_flush;
   logic                         in_last_col, in_last_row;
   logic                         out_last_col, out_last_row;
   logic                         pend_full, flush_ok, emit, interior;

   // ram stage
   logic                         s1_valid_in, s1_valid_ff;
   logic                         s1_pixel_ff, s1_emit_ff, s1_interior_ff;
   logic                         s1_last_ff, s1_sel_mid_ff;
   logic [COL_W-1:0]             s1_addr_ff;
   rmf_pkg::pixel_type           s1_px_ff;

   // line store ram and same-address bypass
   logic                         ram_wr_en, ram_rd_en;
   logic [COL_W-1:0]             ram_rd_addr;
   logic [LINE_W-1:0]            ram_wr_data, ram_rd_data, line_rd;
   logic                         byp_valid_in, byp_valid_ff;
   logic [LINE_W-1:0]            byp_data_ff;
   rmf_pkg::pixel_type           line_above, line_mid;

   // window stage
   rmf_pkg::pixel_type           window_in [rmf_pkg::WIN_SIZE];
   rmf_pkg::pixel_type           window_ff [rmf_pkg::WIN_SIZE];
   rmf_pkg::emit_ctrl_type       s2_ctrl_in, s2_ctrl_ff;
   rmf_pkg::emit_ctrl_type       ctrl_pipe_in [rmf_pkg::LANE_LAT];
   rmf_pkg::emit_ctrl_type       ctrl_pipe_ff [rmf_pkg::LANE_LAT];

   // lanes
   rmf_pkg::window_chan_type     lane_win [rmf_pkg::NUM_LANES];
   rmf_pkg::chan_type            lane_med [rmf_pkg::NUM_LANES];
   rmf_pkg::pixel_type           med_pix;

   assign csr_ready  = 1'b1;
   assign req_tready = advance;
   assign accept     = req_tvalid && advance;
   assign is_flush   = req_tuser;

   // register writes, clamped to the supported frame size
   assign width_raw  = 32'(csr_data[rmf_pkg::CFG_WIDTH_W-1:0]);
   assign height_raw = 32'(csr_data[rmf_pkg::CFG_HEIGHT_W-1:0]);

   always_comb begin
      if (width_raw < 32'(rmf_pkg::MIN_DIM)) begin
         width_clamped = WID_W'(rmf_pkg::MIN_DIM);
      end else if (width_raw > 32'(MAX_WIDTH)) begin
         width_clamped = WID_W'(MAX_WIDTH);
      end else begin
         width_clamped = WID_W'(width_raw);
      end
      if (height_raw < 32'(rmf_pkg::MIN_DIM)) begin
         height_clamped = rmf_pkg::HEIGHT_W'(rmf_pkg::MIN_DIM);
      end else if (height_raw > 32'(rmf_pkg::MAX_HEIGHT)) begin
         height_clamped = rmf_pkg::HEIGHT_W'(rmf_pkg::MAX_HEIGHT);
      end else begin
         height_clamped = rmf_pkg::HEIGHT_W'(height_raw);
      end
   end

   always_comb begin
      eff_width_in  = eff_width_ff;
      eff_height_in = eff_height_ff;
      restart       = 1'b0;
      if (csr_valid) begin
         case (csr_index)
            rmf_pkg::REG_IMAGE_WIDTH: begin
               eff_width_in = width_clamped;
               restart      = 1'b1;
            end
            rmf_pkg::REG_IMAGE_HEIGHT: begin
               eff_height_in = height_clamped;
               restart       = 1'b1;
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end
   end

   // position decode for the accepted beat
   assign in_last_col  = WID_W'(in_col_ff) == eff_width_ff - WID_W'(1);
   assign in_last_row  = rmf_pkg::HEIGHT_W'(in_row_ff) ==
                         eff_height_ff - rmf_pkg::HEIGHT_W'(1);
   assign out_last_col = WID_W'(out_col_ff) == eff_width_ff - WID_W'(1);
   assign out_last_row = rmf_pkg::HEIGHT_W'(out_row_ff) ==
                         eff_height_ff - rmf_pkg::HEIGHT_W'(1);
   assign pend_full    = pending_ff >= PEND_W'(eff_width_ff) + PEND_W'(1);
   assign flush_ok     = (in_col_ff == '0) && (in_row_ff == '0) && (pending_ff != '0);
   assign emit         = is_flush ? flush_ok : pend_full;
   assign interior     = (out_row_ff != '0) &&
                         (rmf_pkg::HEIGHT_W'(out_row_ff) <=
                          eff_height_ff - rmf_pkg::HEIGHT_W'(2)) &&
                         (out_col_ff != '0) &&
                         (WID_W'(out_col_ff) <= eff_width_ff - WID_W'(2));

   // counters
   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      pending_in = pending_ff;
      if (accept) begin
         if (!is_flush) begin
            if (in_last_col) begin
               in_col_in = '0;
               in_row_in = in_last_row ? '0 : in_row_ff + rmf_pkg::ROW_W'(1);
            end else begin
               in_col_in = in_col_ff + COL_W'(1);
            end
            if (!pend_full) begin
               pending_in = pending_ff + PEND_W'(1);
            end
         end else if (flush_ok) begin
            pending_in = pending_ff - PEND_W'(1);
         end
         if (emit) begin
            if (out_last_col) begin
               out_col_in = '0;
               out_row_in = out_last_row ? '0 : out_row_ff + rmf_pkg::ROW_W'(1);
            end else begin
               out_col_in = out_col_ff + COL_W'(1);
            end
         end
      end
      if (restart) begin
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
         pending_in = '0;
      end
   end

   // line store: {above, middle} per column, one read and one write a cycle
   assign advance     = ctrl_ready;
   assign ram_rd_en   = advance;
   assign ram_rd_addr = is_flush ? out_col_ff : in_col_ff;
   assign ram_wr_en   = advance && s1_valid_ff && s1_pixel_ff;
   assign ram_wr_data = {line_mid, s1_px_ff};
   assign s1_valid_in = accept && (!is_flush || flush_ok);
   assign byp_valid_in = ram_wr_en && (s1_addr_ff == ram_rd_addr);

   rmf_ram #(
      .WIDTH (LINE_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (s1_addr_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // the previous beat's write wins over the ram's old contents
   assign line_rd    = byp_valid_ff ? byp_data_ff : ram_rd_data;
   assign line_above = line_rd[LINE_W-1:rmf_pkg::PIX_W];
   assign line_mid   = line_rd[rmf_pkg::PIX_W-1:0];

   // window shift and control for the lanes
   always_comb begin
      for (int i = 0; i < rmf_pkg::WIN_SIZE; i++) begin
         window_in[i] = window_ff[i];
      end
      if (s1_valid_ff && s1_pixel_ff) begin
         for (int r = 0; r < 3; r++) begin
            window_in[3*r]   = window_ff[3*r+1];
            window_in[3*r+1] = window_ff[3*r+2];
         end
         window_in[2] = line_above;
         window_in[5] = line_mid;
         window_in[8] = s1_px_ff;
      end
      s2_ctrl_in.valid    = s1_valid_ff && s1_emit_ff;
      s2_ctrl_in.interior = s1_interior_ff;
      s2_ctrl_in.last     = s1_last_ff;
      if (s1_pixel_ff) begin
         s2_ctrl_in.raw = window_ff[5];
      end else begin
         s2_ctrl_in.raw = s1_sel_mid_ff ? line_mid : line_above;
      end
      ctrl_pipe_in[0] = s2_ctrl_ff;
      for (int i = 1; i < rmf_pkg::LANE_LAT; i++) begin
         ctrl_pipe_in[i] = ctrl_pipe_ff[i-1];
      end
   end

   // pipeline registers, all stages move together
   always_ff @(posedge clock) begin
      if (reset) begin
         eff_width_ff  <= WID_W'(RESET_WIDTH);
         eff_height_ff <= rmf_pkg::HEIGHT_W'(rmf_pkg::RESET_IMAGE_HEIGHT);
         in_col_ff     <= '0;
         in_row_ff     <= '0;
         out_col_ff    <= '0;
         out_row_ff    <= '0;
         pending_ff    <= '0;
         s1_valid_ff   <= 1'b0;
         byp_valid_ff  <= 1'b0;
         s2_ctrl_ff    <= '0;
         for (int i = 0; i < rmf_pkg::WIN_SIZE; i++) begin
            window_ff[i] <= '0;
         end
         for (int i = 0; i < rmf_pkg::LANE_LAT; i++) begin
            ctrl_pipe_ff[i] <= '0;
         end
      end else begin
         eff_width_ff  <= eff_width_in;
         eff_height_ff <= eff_height_in;
         in_col_ff     <= in_col_in;
         in_row_ff     <= in_row_in;
         out_col_ff    <= out_col_in;
         out_row_ff    <= out_row_in;
         pending_ff    <= pending_in;
         if (advance) begin
            s1_valid_ff  <= s1_valid_in;
            byp_valid_ff <= byp_valid_in;
            s2_ctrl_ff   <= s2_ctrl_in;
            for (int i = 0; i < rmf_pkg::WIN_SIZE; i++) begin
               window_ff[i] <= window_in[i];
            end
            for (int i = 0; i < rmf_pkg::LANE_LAT; i++) begin
               ctrl_pipe_ff[i] <= ctrl_pipe_in[i];
            end
         end
      end
      if (advance) begin
         s1_pixel_ff    <= !is_flush;
         s1_emit_ff     <= emit;
         s1_interior_ff <= interior && !is_flush;
         s1_last_ff     <= out_last_row && out_last_col;
         s1_sel_mid_ff  <= out_last_row;
         s1_addr_ff     <= ram_rd_addr;
         s1_px_ff       <= req_tdata;
         byp_data_ff    <= ram_wr_data;
      end
   end

   // one median lane per color channel
   always_comb begin
      for (int l = 0; l < rmf_pkg::NUM_LANES; l++) begin
         for (int i = 0; i < rmf_pkg::WIN_SIZE; i++) begin
            lane_win[l][i] = window_ff[i][l*rmf_pkg::CHAN_W +: rmf_pkg::CHAN_W];
         end
         med_pix[l*rmf_pkg::CHAN_W +: rmf_pkg::CHAN_W] = lane_med[l];
      end
   end

   for (genvar g = 0; g < rmf_pkg::NUM_LANES; g++) begin : g_lane
      rmf_median_lane u_lane (
         .clock  (clock),
         .enable (advance),
         .win_i  (lane_win[g]),
         .med_o  (lane_med[g])
      );
   end

   // merge lanes and buffer the result
   rmf_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .ctrl_i     (ctrl_pipe_ff[rmf_pkg::LANE_LAT-1]),
      .med_i      (med_pix),
      .ready_o    (ctrl_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// ===== sv/rmf_ram.sv =====
// ----------------------------------------------------------------------------
// rmf_ram: generic simple dual-port ram
// One write port and one read port, registered read data with read enable.
// A read of the address being written returns the old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module rmf_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/rmf_median_lane.sv =====
// ----------------------------------------------------------------------------
// rmf_median_lane: pipelined median of nine 8-bit values
// Sorts each window row, then takes max of lows, median of middles and min
// of highs, and the median of those three. Three register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module rmf_median_lane (
   input  wire logic                     clock,
   input  wire logic                     enable,
   input  wire rmf_pkg::window_chan_type win_i,
   output      rmf_pkg::chan_type        med_o
);

   function automatic rmf_pkg::chan_type min2(input rmf_pkg::chan_type a,
                                              input rmf_pkg::chan_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic rmf_pkg::chan_type max2(input rmf_pkg::chan_type a,
                                              input rmf_pkg::chan_type b);
      return (a < b) ? b : a;
   endfunction

   function automatic rmf_pkg::chan_type med3(input rmf_pkg::chan_type a,
                                              input rmf_pkg::chan_type b,
                                              input rmf_pkg::chan_type c);
      return max2(min2(a, b), min2(max2(a, b), c));
   endfunction

   logic [2:0][rmf_pkg::CHAN_W-1:0] lo_in, lo_ff;
   logic [2:0][rmf_pkg::CHAN_W-1:0] mid_in, mid_ff;
   logic [2:0][rmf_pkg::CHAN_W-1:0] hi_in, hi_ff;
   rmf_pkg::chan_type               mx_in, mx_ff;
   rmf_pkg::chan_type               md_in, md_ff;
   rmf_pkg::chan_type               mn_in, mn_ff;
   rmf_pkg::chan_type               med_in, med_ff;

   // stage a: sort each row of the window
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         lo_in[r]  = min2(min2(win_i[3*r], win_i[3*r+1]), win_i[3*r+2]);
         mid_in[r] = med3(win_i[3*r], win_i[3*r+1], win_i[3*r+2]);
         hi_in[r]  = max2(max2(win_i[3*r], win_i[3*r+1]), win_i[3*r+2]);
      end
   end

   // stage b: max of lows, median of middles, min of highs
   always_comb begin
      mx_in = max2(max2(lo_ff[0], lo_ff[1]), lo_ff[2]);
      md_in = med3(mid_ff[0], mid_ff[1], mid_ff[2]);
      mn_in = min2(min2(hi_ff[0], hi_ff[1]), hi_ff[2]);
   end

   // stage c: final median
   assign med_in = med3(mx_ff, md_ff, mn_ff);

   always_ff @(posedge clock) begin
      if (enable) begin
         lo_ff  <= lo_in;
         mid_ff <= mid_in;
         hi_ff  <= hi_in;
         mx_ff  <= mx_in;
         md_ff  <= md_in;
         mn_ff  <= mn_in;
         med_ff <= med_in;
      end
   end

   assign med_o = med_ff;

endmodule

`default_nettype wire

// ===== sv/rmf_merge.sv =====
// ----------------------------------------------------------------------------
// rmf_merge: lane merge and output buffer
// Picks the lane medians for interior pixels or the original pixel on the
// border, and holds results in an output register backed by a skid stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rmf_merge (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire rmf_pkg::emit_ctrl_type ctrl_i,
   input  wire rmf_pkg::pixel_type     med_i,
   output      logic                   ready_o,
   output      logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   output      rmf_pkg::pixel_type     rsp_tdata,
   output      logic                   rsp_tlast
);

   rmf_pkg::pixel_type data;
   logic               push;

   logic               out_valid_in, out_valid_ff;
   rmf_pkg::pixel_type out_data_in, out_data_ff;
   logic               out_last_in, out_last_ff;
   logic               skid_valid_in, skid_valid_ff;
   rmf_pkg::pixel_type skid_data_in, skid_data_ff;
   logic               skid_last_in, skid_last_ff;

   // merge lanes, border pixels keep their original value
   assign data    = ctrl_i.interior ? med_i : ctrl_i.raw;
   assign ready_o = !skid_valid_ff;
   assign push    = ctrl_i.valid && !skid_valid_ff;

   // output register with skid stage
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      out_last_in   = out_last_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      skid_last_in  = skid_last_ff;
      if (!out_valid_ff || rsp_tready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            out_last_in   = skid_last_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = push;
            out_data_in  = data;
            out_last_in  = ctrl_i.last;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = data;
         skid_last_in  = ctrl_i.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      out_last_ff  <= out_last_in;
      skid_data_ff <= skid_data_in;
      skid_last_ff <= skid_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

`default_nettype wire

// ===== sv/rmf_checker.sv =====
// ----------------------------------------------------------------------------
// rmf_checker: port-level checks of the rgb 3x3 median filter
// Watches the request and response channels of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

module rmf_checker (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_tvalid,
   input wire logic                      req_tready,
   input wire logic                      rsp_tvalid,
   input wire logic                      rsp_tready,
   input wire logic [rmf_pkg::PIX_W-1:0] rsp_tdata,
   input wire logic                      rsp_tlast
);

   // a stalled response beat keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("response beat changed while stalled");

   // reset leaves no result pending
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // backpressure on requests only while a result waits and the sink stalled
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !$past(rsp_tready))
      else $error("request stalled without a stalled response");

   // request side is ready right after reset
   a_ready_after_reset: assert property (@(posedge clock)
      reset |=> req_tready)
      else $error("request not ready after reset");

endmodule

bind rgb_median_3x3_filter rmf_checker u_rmf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

// ===== verif/rgb_median_3x3_filter_test.sv =====
// ----------------------------------------------------------------------------
// rgb_median_3x3_filter_test: self-checking bench for the rgb 3x3 median filter
// Streams raster pixel frames and flush beats through the block. Frame sizes
// and register values change between phases, including clamped ones. A
// bit-accurate model of the line stores and the window predicts each
// filtered pixel and its frame_last flag. Results are compared in order.
// Both sides insert random idle cycles, with some phases run without gaps.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_median_3x3_filter_test;

   localparam int MAX_W        = 1024;
   localparam int IDLE_PCT     = 28;
   localparam int DRAIN_CYCLES = 12;
   localparam int RANDOM_BEATS = 1950;

   typedef struct packed {
      logic               flush;
      rmf_pkg::pixel_type px;
   } beat_type;

   typedef struct packed {
      rmf_pkg::pixel_type px;
      logic               last;
   } result_type;

   logic                           clock;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   rmf_pkg::pixel_type             req_tdata  = '0;
   logic                           req_tuser  = 1'b0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   rmf_pkg::pixel_type             rsp_tdata;
   logic                           rsp_tlast;
   logic                           csr_valid  = 1'b0;
   logic                           csr_ready;
   rmf_pkg::csr_reg_type           csr_index  = rmf_pkg::REG_IMAGE_WIDTH;
   logic [rmf_pkg::CSR_DATA_W-1:0] csr_data   = '0;

   // stimulus and expected results
   beat_type    pixel_feed[$];
   result_type  expected_pixels[$];
   int unsigned beats_pushed = 0;
   int unsigned beats_taken  = 0;
   int unsigned failures     = 0;
   bit          gaps_on      = 1'b1;

   // filter model state
   int unsigned            width_reg  = rmf_pkg::RESET_IMAGE_WIDTH;
   int unsigned            height_reg = rmf_pkg::RESET_IMAGE_HEIGHT;
   bit [rmf_pkg::PIX_W-1:0] row_top [MAX_W];
   bit [rmf_pkg::PIX_W-1:0] row_mid [MAX_W];
   bit [rmf_pkg::PIX_W-1:0] window [rmf_pkg::WIN_SIZE];
   int unsigned            in_col, in_row, out_col, out_row, held;

   rgb_median_3x3_filter #(
      .MAX_WIDTH (MAX_W)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // red_in, green_in, blue_in
      .req_tuser  (req_tuser),   // flush
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // red_out, green_out, blue_out
      .rsp_tlast  (rsp_tlast),   // frame_last
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
      return (v < rmf_pkg::MIN_DIM) ? rmf_pkg::MIN_DIM : (v > hi) ? hi : v;
   endfunction

   // median of one channel over the nine window pixels
   function automatic rmf_pkg::chan_type median_of_nine(int lane);
      rmf_pkg::chan_type v [rmf_pkg::WIN_SIZE];
      rmf_pkg::chan_type t;
      int i, j;
      for (i = 0; i < rmf_pkg::WIN_SIZE; i++)
         v[i] = window[i][lane*rmf_pkg::CHAN_W +: rmf_pkg::CHAN_W];
      for (i = 1; i < rmf_pkg::WIN_SIZE; i++) begin
         for (j = i; j > 0 && v[j-1] > v[j]; j--) begin
            t      = v[j];
            v[j]   = v[j-1];
            v[j-1] = t;
         end
      end
      return v[rmf_pkg::WIN_SIZE/2];
   endfunction

   // advance the filter by one beat, returns 1 when a pixel comes out
   function automatic bit filter_step(input beat_type beat, output result_type res);
      int unsigned w, h, r, lane;
      rmf_pkg::pixel_type a, m, outpx;
      w   = clamp_dim(width_reg, MAX_W);
      h   = clamp_dim(height_reg, rmf_pkg::MAX_HEIGHT);
      res = '0;
      if (beat.flush) begin
         // drain only once the whole frame is in and something is held
         if (in_col != 0 || in_row != 0 || held == 0) return 1'b0;
         outpx = (out_row == h - 1) ? row_mid[out_col] : row_top[out_col];
         held--;
      end else begin
         // line stores shift down one row at this column
         a = row_top[in_col];
         m = row_mid[in_col];
         row_top[in_col] = m;
         row_mid[in_col] = beat.px;
         for (r = 0; r < 3; r++) begin
            window[r*3]     = window[r*3 + 1];
            window[r*3 + 1] = window[r*3 + 2];
         end
         window[2] = a;
         window[5] = m;
         window[8] = beat.px;
         in_col++;
         if (in_col >= w) begin
            in_col = 0;
            in_row++;
            if (in_row >= h) in_row = 0;
         end
         held++;
         if (held < w + 2) return 1'b0;
         held = w + 1;
         // interior pixels get the median, border pixels pass through
         if (out_row >= 1 && out_row <= h - 2 && out_col >= 1 && out_col <= w - 2) begin
            for (lane = 0; lane < rmf_pkg::NUM_LANES; lane++)
               outpx[lane*rmf_pkg::CHAN_W +: rmf_pkg::CHAN_W] = median_of_nine(lane);
         end else begin
            outpx = window[4];
         end
      end
      res.px   = outpx;
      res.last = (out_row == h - 1) && (out_col == w - 1);
      out_col++;
      if (out_col >= w) begin
         out_col = 0;
         out_row++;
         if (out_row >= h) out_row = 0;
      end
      return 1'b1;
   endfunction

   function automatic rmf_pkg::pixel_type random_pixel();
      rmf_pkg::pixel_type px;
      int lane;
      px = rmf_pkg::pixel_type'($urandom());
      // saturated channels now and then
      if ($urandom_range(3) == 0) begin
         for (lane = 0; lane < rmf_pkg::NUM_LANES; lane++)
            px[lane*rmf_pkg::CHAN_W +: rmf_pkg::CHAN_W] = $urandom_range(1) ? 8'hff : 8'h00;
      end
      return px;
   endfunction

   function automatic void push_pixel(rmf_pkg::pixel_type px);
      pixel_feed = {pixel_feed, beat_type'({1'b0, px})};
      beats_pushed++;
   endfunction

   function automatic void push_flush(int unsigned n);
      repeat (n) begin
         pixel_feed = {pixel_feed, beat_type'({1'b1, rmf_pkg::pixel_type'($urandom())})};
         beats_pushed++;
      end
   endfunction

   function automatic void check_field(string name, logic [rmf_pkg::CHAN_W-1:0] want,
                                       logic [rmf_pkg::CHAN_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         failures++;
      end
   endfunction

   // request driver, also feeds the model on every accepted beat
   always @(posedge clock) begin
      beat_type   pending_beat;
      result_type produced;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            if (filter_step(beat_type'({req_tuser, req_tdata}), produced))
               expected_pixels = {expected_pixels, produced};
            beats_taken++;
         end
         if (!req_tvalid || req_tready) begin
            if (pixel_feed.size() != 0 && !(gaps_on && $urandom_range(99) < IDLE_PCT)) begin
               pending_beat = pixel_feed.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= pending_beat.px;
               req_tuser  <= pending_beat.flush;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor with random back-pressure
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !(gaps_on && $urandom_range(99) < IDLE_PCT);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_pixels.size() == 0) begin
               $display("%0t: unexpected pixel, expected none, actual %h last %b",
                        $time, rsp_tdata, rsp_tlast);
               failures++;
            end else begin
               want = expected_pixels.pop_front();
               check_field("red", want.px[0*rmf_pkg::CHAN_W +: rmf_pkg::CHAN_W],
                           rsp_tdata[0*rmf_pkg::CHAN_W +: rmf_pkg::CHAN_W]);
               check_field("green", want.px[1*rmf_pkg::CHAN_W +: rmf_pkg::CHAN_W],
                           rsp_tdata[1*rmf_pkg::CHAN_W +: rmf_pkg::CHAN_W]);
               check_field("blue", want.px[2*rmf_pkg::CHAN_W +: rmf_pkg::CHAN_W],
                           rsp_tdata[2*rmf_pkg::CHAN_W +: rmf_pkg::CHAN_W]);
               check_field("frame_last", {7'b0, want.last}, {7'b0, rsp_tlast});
            end
         end
      end
   end

   // register write, the frame counters restart with it
   task automatic write_reg(rmf_pkg::csr_reg_type idx, int unsigned value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value[rmf_pkg::CSR_DATA_W-1:0];
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == rmf_pkg::REG_IMAGE_WIDTH)
         width_reg = value & ((1 << rmf_pkg::CFG_WIDTH_W) - 1);
      else
         height_reg = value & ((1 << rmf_pkg::CFG_HEIGHT_W) - 1);
      in_col  = 0;
      in_row  = 0;
      out_col = 0;
      out_row = 0;
      held    = 0;
   endtask

   task automatic configure(int unsigned w_value, int unsigned h_value);
      if ($urandom_range(1)) begin
         write_reg(rmf_pkg::REG_IMAGE_WIDTH, w_value);
         write_reg(rmf_pkg::REG_IMAGE_HEIGHT, h_value);
      end else begin
         write_reg(rmf_pkg::REG_IMAGE_HEIGHT, h_value);
         write_reg(rmf_pkg::REG_IMAGE_WIDTH, w_value);
      end
   endtask

   // all beats taken, all results seen, then let the pipeline settle
   task automatic wait_idle();
      while (beats_taken != beats_pushed || expected_pixels.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // whole frames back to back with a random tail handling each time
   task automatic frame_phase(int unsigned w_value, int unsigned h_value);
      int unsigned w, h, f, p;
      configure(w_value, h_value);
      w = clamp_dim(w_value, MAX_W);
      h = clamp_dim(h_value, rmf_pkg::MAX_HEIGHT);
      for (f = $urandom_range(1, 3); f > 0; f--) begin
         for (p = 0; p < w * h; p++) begin
            if ($urandom_range(99) < 3) push_flush(1);
            push_pixel(random_pixel());
         end
         case ($urandom_range(3))
            0: ;                                        // next frame pushes the tail out
            1: push_flush($urandom_range(1, w));        // partial drain
            default: push_flush(w + 1 + $urandom_range(2));
         endcase
      end
      wait_idle();
   endtask

   // a frame that is never completed, for very wide or very tall settings
   task automatic partial_phase(int unsigned w_value, int unsigned h_value,
                                int unsigned pixels);
      configure(w_value, h_value);
      repeat (pixels) push_pixel(random_pixel());
      push_flush(2);
      wait_idle();
   endtask

   initial begin
      int unsigned        k, phase, start;
      rmf_pkg::pixel_type px;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // smallest frame: stray flushes, extremes, full drain and an empty flush
      configure(3, 3);
      push_flush(1);
      for (k = 0; k < 9; k++) begin
         px[0*rmf_pkg::CHAN_W +: rmf_pkg::CHAN_W] = (k == 8) ? 8'hff : 8'(k * 29);
         px[1*rmf_pkg::CHAN_W +: rmf_pkg::CHAN_W] =
            8'hff - px[0*rmf_pkg::CHAN_W +: rmf_pkg::CHAN_W];
         px[2*rmf_pkg::CHAN_W +: rmf_pkg::CHAN_W] = k[0] ? 8'hff : 8'(k * 3);
         push_pixel(px);
         if (k == 4) push_flush(1);
      end
      push_flush(5);
      wait_idle();

      // registers below range clamp to a 3x3 frame
      configure(0, 1);
      for (k = 0; k < 9; k++) push_pixel(k[0] ? 24'hffffff : 24'h000000);
      wait_idle();

      // random phases, one long run without gaps at the widest setting
      start = beats_pushed;
      phase = 0;
      while (beats_pushed - start < RANDOM_BEATS) begin
         gaps_on = (phase != 2) && ($urandom_range(4) != 0);
         if (phase == 2)
            partial_phase(2047, 3, MAX_W + 1 + $urandom_range(8, 40));
         else if (phase == 5)
            partial_phase(3, 8191, $urandom_range(30, 60));
         else
            frame_phase(($urandom_range(9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 10),
                        ($urandom_range(9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6));
         phase++;
      end
      gaps_on = 1'b1;
      wait_idle();

      if (failures == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("tb: failure");
      $finish;
   end

endmodule

`default_nettype wire
